FILE: sv/coulomb_exchange_element_core_assert.svh
// Assertion macros shared by the Coulomb/exchange element core.
`ifndef COULOMB_EXCHANGE_ELEMENT_CORE_ASSERT_SVH
`define COULOMB_EXCHANGE_ELEMENT_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CEE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CEE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/cee_pkg.sv
// Shared types and constants for the Coulomb/exchange element core.
package cee_pkg;

    // pair counters run up to a 5-bit basis count, the occupied counter up to a 4-bit count
    localparam int IDX_W = 5;
    localparam int OCC_W = 4;

    localparam logic [1:0] MODE_LOAD_COEF = 2'd0;
    localparam logic [1:0] MODE_LOAD_REP  = 2'd1;
    localparam logic [1:0] MODE_QUERY     = 2'd2;

    localparam logic [1:0] CFG_BASIS_COUNT    = 2'd0;
    localparam logic [1:0] CFG_OCCUPIED_COUNT = 2'd1;
    localparam logic [1:0] CFG_EXCHANGE_MODE  = 2'd2;
    localparam logic [1:0] CFG_SCALE_FACTOR   = 2'd3;

    typedef struct packed {
        logic             query_start;
        logic             coef_rd;
        logic             coef_first;
        logic             rep_rd;
        logic             rep_mul;
        logic             dens_zero;
        logic             hi_mul;
        logic             lo_mul;
        logic             emit_zero;
        logic [OCC_W-1:0] q;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] d;
    } t_dp_cmd;

    typedef struct packed {
        logic             query_ok;
        logic [IDX_W-1:0] basis_n;
        logic [OCC_W-1:0] occ_n;
    } t_dp_status;

endpackage

FILE: sv/coulomb_exchange_element_core.sv
// Top level of the Coulomb/exchange matrix element core.
// Loads (coefficient or repulsion entry) are taken while busy is low and give no result.
// A query for (a,b) returns one saturated element on o_element_value/o_saturated,
// strobed by o_valid for a single cycle; the receiver cannot stall it, so sample
// it in that cycle. With n = min(basis_count, MAX_BASIS) and
// occ = min(occupied_count, MAX_OCCUPIED), the query walks all n*n (c,d) pairs;
// it skips the pairs when n is zero and gives a zero element when a or b lies
// outside the store. The pace is set by the single shared 32x32 multiplier:
// each (c,d) pair takes occ density products, then its repulsion product, with
// a gap while the density sum settles, and two final passes apply the
// scale factor. busy stays high until the strobe; configuration writes are always
// ready and must only be issued while busy is low.
`include "coulomb_exchange_element_core_assert.svh"

module coulomb_exchange_element_core #(
    parameter int MAX_BASIS    = 16,
    parameter int MAX_OCCUPIED = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [2:0]         i_vector_index,
    input  logic [3:0]         i_index_first,
    input  logic [3:0]         i_index_second,
    input  logic [3:0]         i_index_third,
    input  logic [3:0]         i_index_fourth,
    input  logic signed [31:0] i_load_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_element_value,
    output logic               o_saturated
);

    cee_pkg::t_dp_cmd    cmd;
    cee_pkg::t_dp_status status;
    logic                accept;
    logic                cfg_we;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    cee_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    cee_datapath #(
        .MAX_BASIS    (MAX_BASIS),
        .MAX_OCCUPIED (MAX_OCCUPIED)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_mode          (i_mode),
        .i_vector_index  (i_vector_index),
        .i_index_first   (i_index_first),
        .i_index_second  (i_index_second),
        .i_index_third   (i_index_third),
        .i_index_fourth  (i_index_fourth),
        .i_load_value    (i_load_value),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_element_value (o_element_value),
        .o_saturated     (o_saturated),
        .o_valid         (o_valid)
    );

    `CEE_ASSERT_SAME(a_result_when_idle, o_valid, !busy)
    `CEE_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid)
    `CEE_ASSERT_SAME(a_busy_drop_gives_result, $fell(busy), o_valid)
    `CEE_ASSERT_NEXT(a_query_goes_busy, accept && (i_mode == cee_pkg::MODE_QUERY), busy)

endmodule

FILE: sv/cee_ctrl.sv
// Sequencer that walks the (c,d) pairs and the occupied vectors of a query.
module cee_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_mode,
    input  cee_pkg::t_dp_status i_status,
    output cee_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PAIR    = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_SUMWAIT = 3'd3;
    localparam logic [2:0] ST_HI      = 3'd4;
    localparam logic [2:0] ST_LO      = 3'd5;
    localparam logic [2:0] ST_RESWAIT = 3'd6;
    localparam logic [2:0] ST_ZERO    = 3'd7;

    logic [2:0]              r_state, n_state;
    logic [cee_pkg::IDX_W-1:0] r_k, n_k;
    logic [cee_pkg::IDX_W-1:0] r_c, n_c;
    logic [cee_pkg::IDX_W-1:0] r_d, n_d;
    logic                    r_pend, n_pend;
    logic                    k_last;
    logic                    d_last;
    logic                    c_last;
    logic [cee_pkg::IDX_W-1:0] occ_ext;

    assign occ_ext = cee_pkg::IDX_W'(i_status.occ_n);
    // each pair spends occ read slots, then waits for the density to settle
    assign k_last  = (r_k == occ_ext + cee_pkg::IDX_W'(1));
    assign d_last  = (r_d == i_status.basis_n - cee_pkg::IDX_W'(1));
    assign c_last  = (r_c == i_status.basis_n - cee_pkg::IDX_W'(1));
    assign o_busy  = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_c     = r_c;
        n_d     = r_d;
        n_pend  = r_pend;
        o_cmd   = '0;
        o_cmd.q = r_k[cee_pkg::OCC_W-1:0];
        o_cmd.c = r_c;
        o_cmd.d = r_d;
        o_cmd.dens_zero = (i_status.occ_n == '0);
        case (r_state)
            ST_IDLE: begin
                if (i_accept && i_mode == cee_pkg::MODE_QUERY) begin
                    o_cmd.query_start = 1'b1;
                    n_k    = '0;
                    n_c    = '0;
                    n_d    = '0;
                    n_pend = 1'b0;
                    if (!i_status.query_ok) begin
                        n_state = ST_ZERO;
                    end else if (i_status.basis_n == '0) begin
                        n_state = ST_HI;
                    end else begin
                        n_state = ST_PAIR;
                    end
                end
            end
            ST_PAIR: begin
                o_cmd.coef_rd    = (r_k < occ_ext);
                o_cmd.coef_first = (r_k == '0);
                o_cmd.rep_rd     = (r_k == '0);
                // the previous pair's density is final in the first slot of this one
                o_cmd.rep_mul    = (r_k == '0) && r_pend;
                if (k_last) begin
                    n_k    = '0;
                    n_pend = 1'b1;
                    if (d_last) begin
                        n_d = '0;
                        if (c_last) begin
                            n_state = ST_DRAIN;
                        end else begin
                            n_c = r_c + cee_pkg::IDX_W'(1);
                        end
                    end else begin
                        n_d = r_d + cee_pkg::IDX_W'(1);
                    end
                end else begin
                    n_k = r_k + cee_pkg::IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                o_cmd.rep_mul = 1'b1;
                n_state = ST_SUMWAIT;
            end
            ST_SUMWAIT: begin
                n_state = ST_HI;
            end
            ST_HI: begin
                o_cmd.hi_mul = 1'b1;
                n_state = ST_LO;
            end
            ST_LO: begin
                o_cmd.lo_mul = 1'b1;
                n_state = ST_RESWAIT;
            end
            ST_RESWAIT: begin
                n_state = ST_IDLE;
            end
            ST_ZERO: begin
                o_cmd.emit_zero = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_c     <= '0;
            r_d     <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_c     <= n_c;
            r_d     <= n_d;
            r_pend  <= n_pend;
        end
    end

endmodule

FILE: sv/cee_datapath.sv
// Stores, shared multiplier and accumulators of the Coulomb/exchange element core.
module cee_datapath #(
    parameter int MAX_BASIS    = 16,
    parameter int MAX_OCCUPIED = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_mode,
    input  logic [2:0]          i_vector_index,
    input  logic [3:0]          i_index_first,
    input  logic [3:0]          i_index_second,
    input  logic [3:0]          i_index_third,
    input  logic [3:0]          i_index_fourth,
    input  logic signed [31:0]  i_load_value,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  cee_pkg::t_dp_cmd    i_cmd,
    output cee_pkg::t_dp_status o_status,
    output logic signed [31:0]  o_element_value,
    output logic                o_saturated,
    output logic                o_valid
);

    localparam int BW = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
    localparam int PW = (MAX_OCCUPIED > 1) ? $clog2(MAX_OCCUPIED) : 1;
    localparam int REP_DEPTH  = 1 << (4 * BW);
    localparam int COEF_DEPTH = 1 << (PW + BW);

    localparam logic [2:0] TAG_NONE       = 3'd0;
    localparam logic [2:0] TAG_COEF_FIRST = 3'd1;
    localparam logic [2:0] TAG_COEF       = 3'd2;
    localparam logic [2:0] TAG_REP        = 3'd3;
    localparam logic [2:0] TAG_HI         = 3'd4;
    localparam logic [2:0] TAG_LO         = 3'd5;

    localparam logic signed [47:0] DENS_MAX = 48'sd2147483647;
    localparam logic signed [47:0] DENS_MIN = -48'sd2147483648;
    localparam logic signed [63:0] HK_LIM   = 64'sd1099511627776;
    localparam logic signed [63:0] FIN_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] FIN_MIN  = -64'sd2147483648;

    logic [31:0] rep_mem  [REP_DEPTH];
    logic [31:0] coef_mem [COEF_DEPTH];

    logic [4:0]          r_basis;
    logic [3:0]          r_occ;
    logic                r_xmode;
    logic signed [31:0]  r_scale;
    logic [BW-1:0]       r_a;
    logic [BW-1:0]       r_b;
    logic signed [31:0]  r_cx;
    logic signed [31:0]  r_cy;
    logic signed [31:0]  r_rep;
    logic                r_s1_coef;
    logic                r_s1_first;
    logic signed [63:0]  r_prod;
    logic [2:0]          r_tag;
    logic [2:0]          n_tag;
    logic signed [47:0]  r_dacc;
    logic signed [63:0]  r_sum;
    logic signed [63:0]  r_hk;
    logic                r_clip;
    logic signed [31:0]  r_value;
    logic                r_sat;
    logic                r_valid;

    logic                load_coef;
    logic                load_rep;
    logic [PW+BW-1:0]    coef_waddr;
    logic [4*BW-1:0]     rep_waddr;
    logic [PW+BW-1:0]    coef_raddr_c;
    logic [PW+BW-1:0]    coef_raddr_d;
    logic [BW-1:0]       pair_c;
    logic [4*BW-1:0]     rep_raddr;
    logic                dens_hi;
    logic                dens_lo;
    logic signed [31:0]  dens;
    logic signed [31:0]  mul_a;
    logic signed [31:0]  mul_b;
    logic signed [63:0]  mul_p;
    logic signed [39:0]  term;
    logic signed [63:0]  fin;
    logic                fin_clip;
    logic signed [31:0]  fin_value;

    assign o_status.query_ok = (32'(i_index_first) < MAX_BASIS)
                            && (32'(i_index_second) < MAX_BASIS);
    assign o_status.basis_n  = (32'(r_basis) < MAX_BASIS) ? r_basis
                                                           : cee_pkg::IDX_W'(MAX_BASIS);
    assign o_status.occ_n    = (32'(r_occ) < MAX_OCCUPIED) ? r_occ
                                                            : cee_pkg::OCC_W'(MAX_OCCUPIED);

    // loads outside the stores are dropped
    assign load_coef = i_accept && (i_mode == cee_pkg::MODE_LOAD_COEF)
                    && (32'(i_vector_index) < MAX_OCCUPIED)
                    && (32'(i_index_first) < MAX_BASIS);
    assign load_rep  = i_accept && (i_mode == cee_pkg::MODE_LOAD_REP)
                    && (32'(i_index_first) < MAX_BASIS) && (32'(i_index_second) < MAX_BASIS)
                    && (32'(i_index_third) < MAX_BASIS) && (32'(i_index_fourth) < MAX_BASIS);
    assign coef_waddr = {PW'(i_vector_index), BW'(i_index_first)};
    assign rep_waddr  = {BW'(i_index_first), BW'(i_index_second),
                         BW'(i_index_third), BW'(i_index_fourth)};

    assign pair_c       = BW'(i_cmd.c);
    assign coef_raddr_c = {PW'(i_cmd.q), pair_c};
    assign coef_raddr_d = {PW'(i_cmd.q), BW'(i_cmd.d)};
    // exchange swaps the first and third indices
    assign rep_raddr    = r_xmode ? {pair_c, r_b, r_a, BW'(i_cmd.d)}
                                  : {r_a, r_b, pair_c, BW'(i_cmd.d)};

    always_ff @(posedge i_clk) begin
        if (load_coef) begin
            coef_mem[coef_waddr] <= i_load_value;
        end
        if (i_cmd.coef_rd) begin
            r_cx <= coef_mem[coef_raddr_c];
            r_cy <= coef_mem[coef_raddr_d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_rep) begin
            rep_mem[rep_waddr] <= i_load_value;
        end
        if (i_cmd.rep_rd) begin
            r_rep <= rep_mem[rep_raddr];
        end
    end

    assign dens_hi = (r_dacc > DENS_MAX);
    assign dens_lo = (r_dacc < DENS_MIN);
    always_comb begin
        if (i_cmd.dens_zero) begin
            dens = '0;
        end else if (dens_hi) begin
            dens = 32'sh7FFFFFFF;
        end else if (dens_lo) begin
            dens = 32'sh80000000;
        end else begin
            dens = r_dacc[31:0];
        end
    end

    // one shared multiplier; the tag tells the next stage where the product goes
    always_comb begin
        mul_a = r_cx;
        mul_b = r_cy;
        n_tag = TAG_NONE;
        if (i_cmd.rep_mul) begin
            mul_a = r_rep;
            mul_b = dens;
            n_tag = TAG_REP;
        end else if (i_cmd.hi_mul) begin
            // the contracted sum stays below 2^48, so its upper part fits 32 bits
            mul_a = r_sum[55:24];
            mul_b = r_scale;
            n_tag = TAG_HI;
        end else if (i_cmd.lo_mul) begin
            mul_a = {8'd0, r_sum[23:0]};
            mul_b = r_scale;
            n_tag = TAG_LO;
        end else if (r_s1_coef) begin
            n_tag = r_s1_first ? TAG_COEF_FIRST : TAG_COEF;
        end
    end
    assign mul_p = mul_a * mul_b;
    assign term  = r_prod[63:24];

    assign fin = r_hk + 64'(term);
    always_comb begin
        fin_clip  = 1'b0;
        fin_value = fin[31:0];
        if (r_hk > HK_LIM) begin
            fin_clip  = 1'b1;
            fin_value = 32'sh7FFFFFFF;
        end else if (r_hk < -HK_LIM) begin
            fin_clip  = 1'b1;
            fin_value = 32'sh80000000;
        end else if (fin > FIN_MAX) begin
            fin_clip  = 1'b1;
            fin_value = 32'sh7FFFFFFF;
        end else if (fin < FIN_MIN) begin
            fin_clip  = 1'b1;
            fin_value = 32'sh80000000;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_cmd.query_start) begin
            r_a <= BW'(i_index_first);
            r_b <= BW'(i_index_second);
        end
        if (r_tag == TAG_COEF_FIRST) begin
            r_dacc <= 48'(term);
        end else if (r_tag == TAG_COEF) begin
            r_dacc <= r_dacc + 48'(term);
        end
        if (r_tag == TAG_HI) begin
            r_hk <= r_prod;
        end
        if (i_cmd.emit_zero) begin
            r_value <= '0;
            r_sat   <= 1'b0;
        end else if (r_tag == TAG_LO) begin
            r_value <= fin_value;
            r_sat   <= r_clip || fin_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis    <= 5'd16;
            r_occ      <= '0;
            r_xmode    <= 1'b0;
            r_scale    <= 32'sd16777216;
            r_s1_coef  <= 1'b0;
            r_s1_first <= 1'b0;
            r_tag      <= TAG_NONE;
            r_sum      <= '0;
            r_clip     <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cee_pkg::CFG_BASIS_COUNT:    r_basis <= i_cfg_data[4:0];
                    cee_pkg::CFG_OCCUPIED_COUNT: r_occ   <= i_cfg_data[3:0];
                    cee_pkg::CFG_EXCHANGE_MODE:  r_xmode <= i_cfg_data[0];
                    cee_pkg::CFG_SCALE_FACTOR:   r_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            r_s1_coef  <= i_cmd.coef_rd;
            r_s1_first <= i_cmd.coef_first;
            r_tag      <= n_tag;
            if (i_cmd.query_start) begin
                r_sum  <= '0;
                r_clip <= 1'b0;
            end else if (r_tag == TAG_REP) begin
                r_sum <= r_sum + 64'(term);
            end
            if (i_cmd.rep_mul && !i_cmd.dens_zero && (dens_hi || dens_lo)) begin
                r_clip <= 1'b1;
            end
            r_valid <= i_cmd.emit_zero || (r_tag == TAG_LO);
        end
    end

    assign o_element_value = r_value;
    assign o_saturated     = r_sat;
    assign o_valid         = r_valid;

endmodule
